// File: rtl/core/sbe_pkg.sv
`timescale 1ns / 1ps
package sbe_pkg;

  typedef enum logic [3:0] {
    ACT_CLEAR   = 4'd0,
    ACT_INVERT  = 4'd1,
    ACT_ROT_R   = 4'd2,
    ACT_ROT_L   = 4'd3,
    ACT_ROT_UP  = 4'd4,
    ACT_ROT_DN  = 4'd5,
    ACT_FLIP    = 4'd6,
    ACT_MIRROR  = 4'd7,
    ACT_TOGGLE  = 4'd8,
    ACT_PAINT   = 4'd9,
    ACT_READ    = 4'd10,
    ACT_WRITE   = 4'd11
  } act_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_STORE,
    BK_ROW_RD,
    BK_ROW_WB
  } bk_state_e;

  typedef struct packed {
    act_e        action;
    logic [4:0]  sprite;
    logic [3:0]  row;
    logic [3:0]  column;
    logic [15:0] row_word;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  sprite;
    logic [3:0]  row;
    logic [15:0] data;
    logic        pixel_value;
    logic        last;
  } res_t;

  localparam logic [15:0] PIX_MSB  = 16'h8000;
  localparam logic [15:0] PIX_LSB  = 16'h0001;
  localparam logic [3:0]  ROW_LAST = 4'd15;
  localparam logic [4:0]  LOAD_END = 5'd16;

endpackage

// File: rtl/core/sbe_ram.sv
`timescale 1ns / 1ps
module sbe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/sbe_fifo.sv
`timescale 1ns / 1ps
module sbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW:0]      rd_ptr_r, rd_ptr_nxt;
  logic             do_push, do_pop;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[PW] != rd_ptr_r[PW]) && (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r[PW-1:0]];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r[PW-1:0]] <= wdata;
    end
  end

endmodule

// File: rtl/core/sbe_front.sv
`timescale 1ns / 1ps
module sbe_front #(
  parameter int unsigned SPRITE_COUNT = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [3:0]    in_action,
  input  logic [4:0]    in_sprite,
  input  logic [3:0]    in_row,
  input  logic [3:0]    in_column,
  input  logic [15:0]   in_row_word,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output sbe_pkg::cmd_t cmd
);
  import sbe_pkg::*;

  localparam logic [8:0] SPR_LIM = 9'(SPRITE_COUNT);

  cmd_t cmd_in;
  logic item_ok;
  logic q_push;

  // out-of-range sprites and unused codes are dropped here
  assign item_ok = (9'(in_sprite) < SPR_LIM) && (in_action inside {[ACT_CLEAR:ACT_WRITE]});
  assign q_push  = in_push && !in_full && item_ok;

  always_comb begin
    cmd_in.action   = act_e'(in_action);
    cmd_in.sprite   = in_sprite;
    cmd_in.row      = in_row;
    cmd_in.column   = in_column;
    cmd_in.row_word = in_row_word;
  end

  sbe_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// File: rtl/core/sbe_back.sv
`timescale 1ns / 1ps
module sbe_back #(
  parameter int unsigned AW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  sbe_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [15:0]   ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [15:0]   ram_rdata,
  input  logic          res_full,
  output logic          res_push,
  output sbe_pkg::res_t res
);
  import sbe_pkg::*;

  bk_state_e   state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        paint_r, paint_nxt;
  logic [15:0] buf_r [16];

  logic        buf_we;
  logic [3:0]  buf_idx;
  logic [15:0] buf_wdata;
  logic [3:0]  src_idx;
  logic [15:0] mask;
  logic [15:0] row_new;
  logic        pv_new;

  function automatic logic [15:0] rev16(input logic [15:0] w);
    logic [15:0] r;
    for (int j = 0; j < 16; j++) begin
      r[j] = w[15-j];
    end
    return r;
  endfunction

  function automatic logic [15:0] word_op(input act_e a, input logic [15:0] w);
    logic [15:0] n;
    case (a)
      ACT_CLEAR:  n = '0;
      ACT_INVERT: n = ~w;
      ACT_ROT_R:  n = {w[0], w[15:1]};
      ACT_ROT_L:  n = {w[14:0], w[15]};
      ACT_MIRROR: n = rev16(w);
      default:    n = w;
    endcase
    return n;
  endfunction

  // where old row j lands in the new sprite
  function automatic logic [3:0] dest_row(input act_e a, input logic [3:0] j);
    logic [3:0] d;
    case (a)
      ACT_ROT_UP: d = j - 4'd1;
      ACT_ROT_DN: d = j + 4'd1;
      ACT_FLIP:   d = ROW_LAST - j;
      default:    d = j;
    endcase
    return d;
  endfunction

  assign src_idx = 4'(cnt_r - 5'd1);
  assign mask    = PIX_MSB >> cmd_r.column;

  always_comb begin
    row_new = ram_rdata;
    pv_new  = 1'b0;
    case (cmd_r.action)
      ACT_TOGGLE: begin
        row_new = ram_rdata ^ mask;
        pv_new  = |(row_new & mask);
      end
      ACT_PAINT: begin
        row_new = paint_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
        pv_new  = paint_r;
      end
      ACT_WRITE: row_new = cmd_r.row_word;
      default:   row_new = ram_rdata;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = (cmd.action inside {[ACT_CLEAR:ACT_MIRROR]}) ? BK_LOAD : BK_ROW_RD;
        end
      end
      BK_LOAD: begin
        if (cnt_r == LOAD_END) state_nxt = BK_STORE;
      end
      BK_STORE: begin
        if (!res_full && cnt_r[3:0] == ROW_LAST) state_nxt = BK_IDLE;
      end
      BK_ROW_RD: state_nxt = BK_ROW_WB;
      BK_ROW_WB: begin
        if (!res_full) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    paint_nxt = paint_r;
    ram_we    = 1'b0;
    ram_waddr = AW'({cmd_r.sprite, cmd_r.row});
    ram_wdata = row_new;
    ram_re    = 1'b0;
    ram_raddr = AW'({cmd_r.sprite, cmd_r.row});
    buf_we    = 1'b0;
    buf_idx   = dest_row(cmd_r.action, src_idx);
    buf_wdata = word_op(cmd_r.action, ram_rdata);
    res_push  = 1'b0;
    res.sprite      = cmd_r.sprite;
    res.row         = cmd_r.row;
    res.data        = row_new;
    res.pixel_value = pv_new;
    res.last        = 1'b1;
    case (state_r)
      BK_IDLE: begin
        cnt_nxt = '0;
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
        end
      end
      BK_LOAD: begin
        ram_re    = (cnt_r != LOAD_END);
        ram_raddr = AW'({cmd_r.sprite, cnt_r[3:0]});
        buf_we    = (cnt_r != '0);
        cnt_nxt   = (cnt_r == LOAD_END) ? '0 : cnt_r + 5'd1;
      end
      BK_STORE: begin
        ram_waddr = AW'({cmd_r.sprite, cnt_r[3:0]});
        ram_wdata = buf_r[cnt_r[3:0]];
        res.row   = cnt_r[3:0];
        res.data  = buf_r[cnt_r[3:0]];
        res.pixel_value = 1'b0;
        res.last  = (cnt_r[3:0] == ROW_LAST);
        if (!res_full) begin
          ram_we   = 1'b1;
          res_push = 1'b1;
          cnt_nxt  = cnt_r + 5'd1;
        end
      end
      BK_ROW_RD: ram_re = 1'b1;
      BK_ROW_WB: begin
        if (!res_full) begin
          ram_we   = 1'b1;
          res_push = 1'b1;
          if (cmd_r.action inside {ACT_TOGGLE, ACT_PAINT}) paint_nxt = pv_new;
        end
      end
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
      paint_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      paint_r <= paint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (buf_we) begin
      buf_r[buf_idx] <= buf_wdata;
    end
  end

endmodule

// File: rtl/core/sprite_bitmap_edit_engine.sv
`timescale 1ns / 1ps
// Edit engine for SPRITE_COUNT monochrome 16x16 sprites held in one
// single-write, single-read sprite memory. Items are taken into a two-deep
// command queue and carried out one at a time. A whole-sprite action is a
// dispatch, a read of the 16 rows into a staging buffer (already transformed
// and reordered) and a write back, one row and one result per cycle while
// the result queue has room; it is bound by the single read port of the
// memory. Toggle, paint, read and write are a dispatch, a memory read and a
// write back. Results wait in a four-deep queue; a full result queue stalls
// the write back. The memory is not cleared after reset: read only rows that
// have been written.
module sprite_bitmap_edit_engine #(
  parameter int unsigned SPRITE_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_action,
  input  logic [4:0]  in_sprite,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_column,
  input  logic [15:0] in_row_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_sprite,
  output logic [3:0]  out_row,
  output logic [15:0] out_data,
  output logic        out_pixel_value,
  output logic        out_last
);
  import sbe_pkg::*;

  localparam int unsigned RAM_DEPTH = SPRITE_COUNT * 16;
  localparam int unsigned AW        = $clog2(RAM_DEPTH);

  cmd_t          cmd;
  logic          cmd_pop, cmd_empty;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic          res_push, res_full;
  res_t          res_in, res_out;

  sbe_front #(
    .SPRITE_COUNT (SPRITE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_action   (in_action),
    .in_sprite   (in_sprite),
    .in_row      (in_row),
    .in_column   (in_column),
    .in_row_word (in_row_word),
    .cmd_pop     (cmd_pop),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd)
  );

  sbe_back #(
    .AW (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  sbe_ram #(
    .WIDTH (16),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sbe_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (4)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_sprite      = res_out.sprite;
  assign out_row         = res_out.row;
  assign out_data        = res_out.data;
  assign out_pixel_value = res_out.pixel_value;
  assign out_last        = res_out.last;

  a_cmd_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> res_push)
    else $error("sprite row written without a result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sbe_pkg::*;

  localparam int          SPRITES       = 32;
  localparam int          SCRIPT_LEN    = 25;
  localparam int          ITEMS_PER_RUN = 72;
  localparam logic [3:0]  ACT_SPARE_LO  = 4'd12;
  localparam logic [3:0]  ACT_SPARE_HI  = 4'd15;

  typedef struct {
    logic [3:0]  action;
    logic [4:0]  sprite;
    logic [3:0]  row;
    logic [3:0]  column;
    logic [15:0] row_word;
  } edit_cmd_t;

  typedef struct {
    edit_cmd_t   cmd;
    bit          typed;
    logic [15:0] exp_data;
    bit          exp_pv;
  } script_step_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [3:0]  in_action;
  logic [4:0]  in_sprite;
  logic [3:0]  in_row;
  logic [3:0]  in_column;
  logic [15:0] in_row_word;
  logic        out_empty;
  logic        out_pop;
  logic [4:0]  out_sprite;
  logic [3:0]  out_row;
  logic [15:0] out_data;
  logic        out_pixel_value;
  logic        out_last;

  logic [15:0] bitmap [SPRITES][16];
  bit          paint_bit;
  bit          row_set [SPRITES][16];
  res_t        fresh_rows [$];
  res_t        awaited_rows [$];
  res_t        want_row;
  int          errors;
  int          cmds_sent;
  int          cmds_ignored;
  int          rows_checked;
  int          tx_idle_pct;
  int          rx_idle_pct;

  // script steps; expectations are typed for writes, clears, pixel edits and reads whose outcome is plain
  script_step_t script [SCRIPT_LEN] = '{
    '{'{ACT_WRITE,  5'd0,  4'd0,  4'd0,  16'hFFFF}, 1'b1, 16'hFFFF, 1'b0},
    '{'{ACT_CLEAR,  5'd0,  4'd0,  4'd0,  16'h0000}, 1'b1, 16'h0000, 1'b0},
    '{'{ACT_WRITE,  5'd0,  4'd0,  4'd7,  16'h8001}, 1'b1, 16'h8001, 1'b0},
    '{'{ACT_WRITE,  5'd0,  4'd15, 4'd0,  16'hC3A5}, 1'b1, 16'hC3A5, 1'b0},
    '{'{ACT_ROT_R,  5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_ROT_L,  5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_ROT_UP, 5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_ROT_DN, 5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_FLIP,   5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_MIRROR, 5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_INVERT, 5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_TOGGLE, 5'd0,  4'd0,  4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_PAINT,  5'd0,  4'd1,  4'd15, 16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_TOGGLE, 5'd0,  4'd15, 4'd15, 16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_PAINT,  5'd0,  4'd15, 4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_READ,   5'd0,  4'd15, 4'd0,  16'h0000}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_CLEAR,  5'd31, 4'd15, 4'd15, 16'hFFFF}, 1'b1, 16'h0000, 1'b0},
    '{'{ACT_WRITE,  5'd31, 4'd15, 4'd15, 16'hFFFF}, 1'b1, 16'hFFFF, 1'b0},
    '{'{ACT_TOGGLE, 5'd31, 4'd15, 4'd15, 16'h0000}, 1'b1, 16'hFFFE, 1'b0},
    '{'{ACT_PAINT,  5'd31, 4'd15, 4'd0,  16'h0000}, 1'b1, 16'h7FFE, 1'b0},
    '{'{ACT_TOGGLE, 5'd31, 4'd15, 4'd0,  16'h0000}, 1'b1, 16'hFFFE, 1'b1},
    '{'{ACT_READ,   5'd31, 4'd15, 4'd0,  16'h0000}, 1'b1, 16'hFFFE, 1'b0},
    '{'{ACT_SPARE_LO, 5'd0, 4'd3, 4'd3,  16'h1234}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_SPARE_HI, 5'd31, 4'd15, 4'd15, 16'hFFFF}, 1'b0, 16'h0000, 1'b0},
    '{'{ACT_WRITE,  5'd31, 4'd0,  4'd0,  16'h0000}, 1'b1, 16'h0000, 1'b0}
  };

  sprite_bitmap_edit_engine #(.SPRITE_COUNT(SPRITES)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_sprite       (in_sprite),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_row_word     (in_row_word),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_sprite      (out_sprite),
    .out_row         (out_row),
    .out_data        (out_data),
    .out_pixel_value (out_pixel_value),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // new sprite rows that one command produces, into fresh_rows
  function automatic void edit_sprite(input edit_cmd_t c);
    logic [15:0] snap [16];
    logic [15:0] mask;
    logic [15:0] w;
    res_t        r;
    mask = PIX_MSB >> c.column;
    fresh_rows.delete();
    if (c.sprite >= SPRITES || c.action > ACT_WRITE) return;
    r.sprite = c.sprite;
    r.row = c.row;
    r.pixel_value = 1'b0;
    r.last = 1'b1;
    if (c.action <= ACT_MIRROR) begin
      for (int i = 0; i < 16; i++) snap[i] = bitmap[c.sprite][i];
      for (int i = 0; i < 16; i++) begin
        w = snap[i];
        case (c.action)
          ACT_CLEAR:  w = 16'h0000;
          ACT_INVERT: w = ~w;
          ACT_ROT_R:  w = {w[0], w[15:1]};
          ACT_ROT_L:  w = {w[14:0], w[15]};
          ACT_ROT_UP: w = snap[4'(i + 1)];
          ACT_ROT_DN: w = snap[4'(i + 15)];
          ACT_FLIP:   w = snap[15 - i];
          default:    w = {<<{w}};
        endcase
        bitmap[c.sprite][i] = w;
        r.row = 4'(i);
        r.data = w;
        r.last = (4'(i) == ROW_LAST);
        fresh_rows.push_back(r);
      end
      return;
    end
    case (c.action)
      ACT_TOGGLE: begin
        bitmap[c.sprite][c.row] ^= mask;
        paint_bit = (bitmap[c.sprite][c.row] & mask) != 16'h0000;
        r.pixel_value = paint_bit;
      end
      ACT_PAINT: begin
        if (paint_bit) bitmap[c.sprite][c.row] |= mask;
        else bitmap[c.sprite][c.row] &= ~mask;
        r.pixel_value = paint_bit;
      end
      ACT_WRITE: bitmap[c.sprite][c.row] = c.row_word;
      default: ;
    endcase
    r.data = bitmap[c.sprite][c.row];
    fresh_rows.push_back(r);
  endfunction

  // drive one command until the block takes it, then book its rows
  task automatic issue(input edit_cmd_t c, input bit typed, input logic [15:0] exp_data,
                       input bit exp_pv);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push     <= 1'b1;
    in_action   <= c.action;
    in_sprite   <= c.sprite;
    in_row      <= c.row;
    in_column   <= c.column;
    in_row_word <= c.row_word;
    @(posedge clk);
    while (in_full) @(posedge clk);
    edit_sprite(c);
    foreach (fresh_rows[k]) begin
      if (typed) begin
        fresh_rows[k].data = exp_data;
        fresh_rows[k].pixel_value = exp_pv;
      end
      awaited_rows.push_back(fresh_rows[k]);
    end
    if (c.action > ACT_WRITE) cmds_ignored++;
    else cmds_sent++;
    if (c.action <= ACT_MIRROR) begin
      for (int i = 0; i < 16; i++) row_set[c.sprite][i] = 1'b1;
    end else if (c.action == ACT_WRITE) begin
      row_set[c.sprite][c.row] = 1'b1;
    end
  endtask

  // random command that never reads a row that has not been written
  task automatic random_cmd();
    edit_cmd_t c;
    bit        whole;
    c.action   = 4'($urandom_range(ACT_WRITE));
    c.sprite   = ($urandom_range(99) < 80) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    c.row      = 4'($urandom_range(15));
    c.column   = 4'($urandom_range(15));
    c.row_word = 16'($urandom);
    if ($urandom_range(99) < 15) c.row_word = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    whole = 1'b1;
    for (int i = 0; i < 16; i++) whole &= row_set[c.sprite][i];
    if (c.action != ACT_CLEAR && c.action <= ACT_MIRROR && !whole) c.action = ACT_CLEAR;
    if (c.action >= ACT_TOGGLE && c.action <= ACT_READ && !row_set[c.sprite][c.row])
      c.action = ACT_WRITE;
    if ($urandom_range(99) < 6) c.action = 4'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    issue(c, 1'b0, 16'h0000, 1'b0);
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_rows.size() == 0) begin
        $error("unexpected row: sprite %0d row %0d data %h", out_sprite, out_row, out_data);
        errors++;
      end else begin
        want_row = awaited_rows.pop_front();
        rows_checked++;
        if (out_sprite !== want_row.sprite) begin
          $error("out_sprite: expected %0d, got %0d", want_row.sprite, out_sprite);
          errors++;
        end
        if (out_row !== want_row.row) begin
          $error("out_row: expected %0d, got %0d", want_row.row, out_row);
          errors++;
        end
        if (out_data !== want_row.data) begin
          $error("out_data: expected %h, got %h", want_row.data, out_data);
          errors++;
        end
        if (out_pixel_value !== want_row.pixel_value) begin
          $error("out_pixel_value: expected %0d, got %0d", want_row.pixel_value,
                 out_pixel_value);
          errors++;
        end
        if (out_last !== want_row.last) begin
          $error("out_last: expected %0d, got %0d", want_row.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int goal;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_action   = ACT_CLEAR;
    in_sprite   = 5'd0;
    in_row      = 4'd0;
    in_column   = 4'd0;
    in_row_word = 16'h0000;
    paint_bit   = 1'b0;
    errors      = 0;
    tx_idle_pct = 28;
    rx_idle_pct = 86;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[n]) issue(script[n].cmd, script[n].typed, script[n].exp_data,
                              script[n].exp_pv);

    for (int run = 0; run < 3; run++) begin
      tx_idle_pct = (run == 0) ? 28 : (run == 1) ? 86 : 0;
      rx_idle_pct = (run == 0) ? 86 : (run == 1) ? 28 : 0;
      goal = cmds_sent + ITEMS_PER_RUN;
      while (cmds_sent < goal) random_cmd();
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (awaited_rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (awaited_rows.size() != 0) begin
      $error("%0d rows never came out", awaited_rows.size());
      errors++;
    end
    $display("Edit commands taken: %0d, ignored codes: %0d, rows checked: %0d",
             cmds_sent, cmds_ignored, rows_checked);
    $display("All twelve actions under three sender/receiver stall mixes");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sbe_pkg.sv
rtl/core/sbe_ram.sv
rtl/core/sbe_fifo.sv
rtl/core/sbe_front.sv
rtl/core/sbe_back.sv
rtl/core/sprite_bitmap_edit_engine.sv
bench/tb_top.sv
